[src/sbda_pkg.sv]
// Shared constants and controller/datapath handshake types for the decimal text converter.
`default_nettype none
package sbda_pkg;

	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_MINUS = 8'd45;

	typedef struct packed {
		logic load;
		logic convert;
		logic norm;
		logic shift_out;
		logic emit_sign;
	} sbda_cmd_t;

	typedef struct packed {
		logic neg;
		logic conv_done;
		logic top_zero;
		logic one_left;
	} sbda_sts_t;

endpackage
`default_nettype wire

[src/sbda_if.sv]
// Valid/ready channel interfaces for the integer input and the character output.
`default_nettype none
interface sbda_in_if #(
	parameter int VALUE_BITS = 32
);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface sbda_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last;

	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);
endinterface
`default_nettype wire

[src/sbda_datapath.sv]
// Datapath: magnitude shifter, bit-serial BCD converter and digit output shifter.
`default_nettype none
module sbda_datapath
	import sbda_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire sbda_cmd_t             cmd,
	input  wire logic [VALUE_BITS-1:0] value,
	output sbda_sts_t                  sts,
	output logic [7:0]                 character,
	output logic                       last
);

	localparam int NUM_DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
	localparam int BCD_W      = 4 * NUM_DIGITS;
	localparam int CNT_W      = $clog2(VALUE_BITS + 1);
	localparam int DIG_W      = $clog2(NUM_DIGITS + 1);

	logic [VALUE_BITS-1:0] mag_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      bcd_adj;
	logic                  neg_q;
	logic [CNT_W-1:0]      bit_cnt_q;
	logic [DIG_W-1:0]      ndig_q;
	logic [3:0]            top_digit;

	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q     <= value[VALUE_BITS-1];
			mag_q     <= value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
			bcd_q     <= '0;
			bit_cnt_q <= CNT_W'(VALUE_BITS);
			ndig_q    <= DIG_W'(NUM_DIGITS);
		end else if (cmd.convert) begin
			bcd_q     <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_BITS-1]};
			mag_q     <= {mag_q[VALUE_BITS-2:0], 1'b0};
			bit_cnt_q <= bit_cnt_q - CNT_W'(1);
		end else if (cmd.norm || cmd.shift_out) begin
			bcd_q  <= {bcd_q[BCD_W-5:0], 4'd0};
			ndig_q <= ndig_q - DIG_W'(1);
		end
	end

	assign top_digit = bcd_q[BCD_W-1 -: 4];

	assign sts.neg       = neg_q;
	assign sts.conv_done = (bit_cnt_q == '0);
	assign sts.top_zero  = (top_digit == 4'd0);
	assign sts.one_left  = (ndig_q == DIG_W'(1));

	assign character = cmd.emit_sign ? CHAR_MINUS : (CHAR_ZERO | {4'd0, top_digit});
	assign last      = !cmd.emit_sign && (ndig_q == DIG_W'(1));

	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (bcd_q == '0) && (bit_cnt_q == CNT_W'(VALUE_BITS)))
		else $error("load did not clear the converter");
	a_norm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.norm |-> sts.top_zero && !sts.one_left)
		else $error("dropped a significant digit");
	a_convert_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.convert |-> bit_cnt_q != '0)
		else $error("convert beyond the value width");
	a_emit_digits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_out |-> ndig_q != '0 && bit_cnt_q == '0)
		else $error("digit emitted with none left or before conversion end");

endmodule
`default_nettype wire

[src/sbda_ctrl.sv]
// Controller: sequences load, conversion, leading-zero removal and character output.
`default_nettype none
module sbda_ctrl
	import sbda_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire sbda_sts_t sts,
	output sbda_cmd_t      cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CONV  = 3'd1;
	localparam logic [2:0] ST_NORM  = 3'd2;
	localparam logic [2:0] ST_SIGN  = 3'd3;
	localparam logic [2:0] ST_DIGIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				if (sts.conv_done) begin
					state_d = ST_NORM;
				end else begin
					cmd.convert = 1'b1;
				end
			end
			ST_NORM: begin
				if (sts.top_zero && !sts.one_left) begin
					cmd.norm = 1'b1;
				end else if (sts.neg) begin
					state_d = ST_SIGN;
				end else begin
					state_d = ST_DIGIT;
				end
			end
			ST_SIGN: begin
				out_valid     = 1'b1;
				cmd.emit_sign = 1'b1;
				if (out_ready) begin
					state_d = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.shift_out = 1'b1;
					if (sts.one_left) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_sign_then_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SIGN) && out_ready |=> state_q == ST_DIGIT)
		else $error("minus sign not followed by digits");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.convert, cmd.norm, cmd.shift_out}))
		else $error("conflicting datapath commands");
	a_sign_only_neg: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_sign |-> sts.neg)
		else $error("minus sign for a non-negative value");

endmodule
`default_nettype wire

[src/signed_binary_to_decimal_ascii_core.sv]
// Top level: signed integer to decimal ASCII text converter.
`default_nettype none
// Takes one signed VALUE_BITS-bit integer per transfer on number and returns its
// decimal text on text, one ASCII character per transfer, most significant digit
// first, with a leading '-' for negative values, no leading zeros, and last set on
// the final character. One number is handled at a time: the binary magnitude is
// shifted bit-serially through a BCD double-dabble register, one bit per cycle,
// then leading zero digits are dropped one per cycle before output starts.
// Characters wait while text.ready is low, and no new number is taken until the
// last character of the previous one has been sent.
module signed_binary_to_decimal_ascii_core
	import sbda_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	sbda_in_if.sink   number,
	sbda_out_if.source text
);

	sbda_cmd_t cmd;
	sbda_sts_t sts;

	sbda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (number.valid),
		.in_ready  (number.ready),
		.out_valid (text.valid),
		.out_ready (text.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sbda_datapath #(
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.value     (number.value),
		.sts       (sts),
		.character (text.character),
		.last      (text.last)
	);

endmodule
`default_nettype wire

[tb/tb_signed_binary_to_decimal_ascii_core.sv]
// Testbench for the signed integer to decimal ASCII converter, checked against its own predictor.
`default_nettype none
module tb_signed_binary_to_decimal_ascii_core
	import sbda_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int VALUE_BITS = 32;
	localparam int unsigned POW10 [0:9] = '{1, 10, 100, 1000, 10000, 100000, 1000000,
		10000000, 100000000, 1000000000};

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} text_char_t;

	typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

	logic clk;
	logic arst_n;

	sbda_in_if #(.VALUE_BITS(VALUE_BITS)) number_if ();
	sbda_out_if text_if ();

	signed_binary_to_decimal_ascii_core #(
		.VALUE_BITS(VALUE_BITS)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.number (number_if),
		.text   (text_if)
	);

	text_char_t  pending_text [$];
	int          mismatches;
	int          numbers_accepted;
	int          negatives_accepted;
	int          chars_checked;
	int          burst_left;
	int          gap_max;
	int          hold_off_cycles;
	rx_mode_t    rx_mode;
	logic [15:0] rx_pattern;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("tb_signed_binary_to_decimal_ascii_core: done, errors");
		$finish;
	end

	// Expected characters of one number, most significant digit first
	task automatic predict_text(input logic [VALUE_BITS-1:0] value);
		logic [VALUE_BITS-1:0] magnitude;
		logic [7:0]            digit_chars [$];
		text_char_t            c;
		magnitude = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
		if (value[VALUE_BITS-1]) begin
			c.character = CHAR_MINUS;
			c.last = 1'b0;
			pending_text.push_back(c);
			negatives_accepted++;
		end
		do begin
			digit_chars.push_front(CHAR_ZERO + 8'(magnitude % 10));
			magnitude = magnitude / 10;
		end while (magnitude != 0);
		foreach (digit_chars[i]) begin
			c.character = digit_chars[i];
			c.last = (i == digit_chars.size() - 1);
			pending_text.push_back(c);
		end
	endtask

	always @(posedge clk) begin
		text_char_t want;
		if (arst_n) begin
			if (number_if.valid && number_if.ready) begin
				predict_text(number_if.value);
				numbers_accepted++;
			end
			if (text_if.valid && text_if.ready) begin
				chars_checked++;
				if (pending_text.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%t: unexpected character %0d last %b, none pending",
							$realtime, text_if.character, text_if.last);
				end else begin
					want = pending_text.pop_front();
					if (text_if.character !== want.character || text_if.last !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%t: character exp %0d last %b, got %0d last %b",
								$realtime, want.character, want.last,
								text_if.character, text_if.last);
					end
				end
			end
		end
	end

	initial begin
		int held;
		text_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				text_if.ready <= 1'b0;
				for (held = 0; held < hold_off_cycles; held++)
					@(posedge clk);
				hold_off_cycles = 0;
			end else begin
				case (rx_mode)
					RX_ALWAYS: text_if.ready <= 1'b1;
					RX_RANDOM: text_if.ready <= ($urandom_range(99, 0) >= 35);
					RX_PATTERN: begin
						text_if.ready <= rx_pattern[0];
						rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
					end
					default: text_if.ready <= 1'b1;
				endcase
			end
		end
	end

	function automatic logic [VALUE_BITS-1:0] random_number();
		int unsigned digits;
		int unsigned hi;
		int unsigned mag;
		logic        negative;
		negative = 1'($urandom_range(1, 0));
		case ($urandom_range(3, 0))
			0: return $urandom();
			1: begin
				digits = $urandom_range(10, 1);
				hi = (digits == 10) ? 32'd2147483647 : POW10[digits] - 1;
				mag = $urandom_range(hi, POW10[digits-1]);
			end
			2: begin
				digits = $urandom_range(9, 1);
				mag = POW10[digits] + $urandom_range(2, 0) - 1;
			end
			default: mag = $urandom_range(20, 0);
		endcase
		return negative ? -mag : mag;
	endfunction

	// Send one number; open a new burst after a random gap
	task automatic send_number(input logic [VALUE_BITS-1:0] value);
		int gap;
		if (burst_left == 0) begin
			gap = (gap_max > 0) ? $urandom_range(gap_max, 0) : 0;
			if (gap > 0) begin
				number_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(8, 1);
		end
		burst_left--;
		number_if.valid <= 1'b1;
		number_if.value <= value;
		do @(posedge clk); while (!number_if.ready);
	endtask

	task automatic drain_text(input int settle);
		number_if.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_text.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic test_directed();
		logic [VALUE_BITS-1:0] corner [$];
		gap_max = 0;
		rx_mode = RX_ALWAYS;
		corner = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
			32'd999999999, -32'sd999999999, 32'd1234567890, -32'sd1234567890,
			32'h5555_5555, 32'hAAAA_AAAA, -32'sd9, 32'd7, 32'hFFFF_FFF6};
		foreach (corner[i])
			send_number(corner[i]);
		drain_text(8);
	endtask

	task automatic test_streaming();
		gap_max = 0;
		rx_mode = RX_ALWAYS;
		repeat (60) send_number(random_number());
		drain_text(8);
	endtask

	task automatic test_random_idle();
		gap_max = 20;
		rx_mode = RX_RANDOM;
		repeat (60) send_number(random_number());
		drain_text(8);
	endtask

	task automatic test_patterned_stall();
		gap_max = 6;
		rx_mode = RX_PATTERN;
		rx_pattern = 16'($urandom()) | 16'h0001;
		repeat (60) send_number(random_number());
		drain_text(8);
	endtask

	// Hold the output off so the block fills and stalls its input
	task automatic test_backpressure();
		gap_max = 0;
		rx_mode = RX_RANDOM;
		hold_off_cycles = 400;
		repeat (12) send_number(random_number());
		hold_off_cycles = 250;
		repeat (8) send_number(random_number());
		drain_text(8);
	endtask

	initial begin
		mismatches = 0;
		numbers_accepted = 0;
		negatives_accepted = 0;
		chars_checked = 0;
		burst_left = 0;
		gap_max = 0;
		hold_off_cycles = 0;
		rx_mode = RX_ALWAYS;
		rx_pattern = 16'hFFFF;
		arst_n <= 1'b0;
		number_if.valid <= 1'b0;
		number_if.value <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_streaming();
		test_random_idle();
		test_backpressure();
		test_patterned_stall();

		drain_text(60);
		if (pending_text.size() != 0) begin
			mismatches++;
			$display("%0d characters never arrived", pending_text.size());
		end

		$display("converted %0d numbers (%0d negative), %0d characters checked",
			numbers_accepted, negatives_accepted, chars_checked);
		$display("covered corners, bursts, random and patterned stalls, long hold-offs; %0d mismatches",
			mismatches);
		if (mismatches == 0)
			$display("tb_signed_binary_to_decimal_ascii_core: done, clean");
		else
			$display("tb_signed_binary_to_decimal_ascii_core: done, errors");
		$finish;
	end

endmodule
`default_nettype wire

[signed_binary_to_decimal_ascii_core.f]
src/sbda_pkg.sv
src/sbda_if.sv
src/sbda_datapath.sv
src/sbda_ctrl.sv
src/signed_binary_to_decimal_ascii_core.sv
tb/tb_signed_binary_to_decimal_ascii_core.sv
